[src/qsv_pkg.sv]
package qsv_pkg;

    // Default sizes
    localparam int MAX_QUBIT_COUNT_DEF = 16;
    localparam int AMP_FRAC_BITS_DEF   = 16;

    // Fixed field widths
    localparam int CMD_W    = 4;
    localparam int QUBIT_W  = 4;
    localparam int NQ_W     = 5;
    localparam int RAND_W   = 17;
    localparam int INDEX_W  = 16;
    localparam int STATUS_W = 2;
    localparam int S_DATA_W = 48;

    // Command codes
    localparam logic [CMD_W-1:0] CMD_H    = 4'd0;
    localparam logic [CMD_W-1:0] CMD_X    = 4'd1;
    localparam logic [CMD_W-1:0] CMD_Y    = 4'd2;
    localparam logic [CMD_W-1:0] CMD_Z    = 4'd3;
    localparam logic [CMD_W-1:0] CMD_S    = 4'd4;
    localparam logic [CMD_W-1:0] CMD_T    = 4'd5;
    localparam logic [CMD_W-1:0] CMD_CX   = 4'd6;
    localparam logic [CMD_W-1:0] CMD_SWAP = 4'd7;
    localparam logic [CMD_W-1:0] CMD_MEAS = 4'd8;
    localparam logic [CMD_W-1:0] CMD_READ = 4'd9;
    localparam logic [CMD_W-1:0] CMD_INIT = 4'd10;

    // Status codes
    localparam logic [STATUS_W-1:0] STAT_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] STAT_RANGE = 2'd1;
    localparam logic [STATUS_W-1:0] STAT_SAME  = 2'd2;

    typedef enum logic [2:0] {
        K_H = 3'd0,
        K_X = 3'd1,
        K_Y = 3'd2,
        K_Z = 3'd3,
        K_S = 3'd4,
        K_T = 3'd5
    } gate_kind_t;

    typedef struct packed {
        logic       en;
        gate_kind_t kind;
    } alu_ctl_t;

    typedef enum logic [3:0] {
        ST_CLR_RST,
        ST_IDLE,
        ST_SCAN,
        ST_PAIR_RX,
        ST_PAIR_RY,
        ST_PAIR_MUL,
        ST_PAIR_WX,
        ST_PAIR_WY,
        ST_MS_RD,
        ST_MS_SQ,
        ST_MS_ACC,
        ST_RD_ISSUE,
        ST_RD_DATA,
        ST_CLR_CMD,
        ST_DONE
    } ctrl_state_t;

    // Round(2^f / sqrt2) by integer square root of 2^(2f-1)
    function automatic longint unsigned root_half(int f);
        longint unsigned x;
        longint unsigned r;
        longint unsigned b;
        int k;
        x = 64'd1 << (2 * f - 1);
        r = 64'd0;
        b = 64'd1 << 62;
        for (k = 0; k < 32; k++) begin
            if (b > x) begin
                b = b >> 2;
            end
        end
        for (k = 0; k < 32; k++) begin
            if (b != 64'd0) begin
                if (x >= r + b) begin
                    x = x - (r + b);
                    r = (r >> 1) + b;
                end else begin
                    r = r >> 1;
                end
                b = b >> 2;
            end
        end
        if (x > r) begin
            r = r + 64'd1;
        end
        return r;
    endfunction

endpackage

[src/quantum_state_vector_gate_engine.sv]
// Quantum state-vector gate engine.
// Input stream s_*: one command word per handshake (gate, cx, swap, measure,
// read amplitude, init). Output stream m_*: exactly one result word per command.
// Configuration channel cfg_*: writes num_qubits; always ready, write only when
// no command is in flight.
// Amplitudes live in one memory of 2^MAX_QUBIT_COUNT entries with a registered
// read port; a sequencer reads, modifies and writes one entry pair at a time.
// A one-qubit gate, cx or swap scans the indices and handles each pair by
// reading both entries, running the ALU and writing both entries back;
// measure reads and sums the squared magnitudes entry by entry until the
// sum reaches r; init rewrites every entry.
// One command is worked on at a time; the next word is accepted while the
// previous result still waits in the output register.
// Reset (aresetn low, synchronous) sets num_qubits to 1 and starts a clearing
// pass that loads basis state zero; s_tready stays low until it ends. A stalled
// m_tready holds the result and, once the next command finishes, holds the
// engine too.
module quantum_state_vector_gate_engine #(
    parameter int MAX_QUBIT_COUNT = qsv_pkg::MAX_QUBIT_COUNT_DEF,
    parameter int AMP_FRAC_BITS   = qsv_pkg::AMP_FRAC_BITS_DEF,
    localparam int AMP_W   = AMP_FRAC_BITS + 2,
    localparam int M_RAW_W = qsv_pkg::STATUS_W + qsv_pkg::INDEX_W + 2 * AMP_W,
    localparam int M_DATA_W = ((M_RAW_W + 7) / 8) * 8
) (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_tvalid,
    output logic                            s_tready,
    // cmd[3:0], qubit_a[7:4], qubit_b[11:8], random_fraction[28:12],
    // amp_index[44:29], zero fill
    input  logic [qsv_pkg::S_DATA_W-1:0]    s_tdata,
    output logic                            m_tvalid,
    input  logic                            m_tready,
    // status, measured_index, amp_real, amp_imag from bit 0 up, zero fill
    output logic [M_DATA_W-1:0]             m_tdata,
    input  logic                            cfg_valid,
    output logic                            cfg_ready,
    input  logic [qsv_pkg::NQ_W-1:0]        cfg_data
);

    logic [qsv_pkg::NQ_W-1:0]      num_qubits_reg;
    logic                          m_valid_reg, m_valid_next;
    logic [M_DATA_W-1:0]           m_data_reg;
    logic                          out_free;
    logic                          res_valid;
    logic [qsv_pkg::STATUS_W-1:0]  res_status;
    logic [qsv_pkg::INDEX_W-1:0]   res_index;
    logic signed [AMP_W-1:0]       res_re, res_im;

    qsv_ctrl #(
        .MAX_QUBIT_COUNT (MAX_QUBIT_COUNT),
        .AMP_FRAC_BITS   (AMP_FRAC_BITS)
    ) u_ctrl (
        .aclk            (aclk),
        .aresetn         (aresetn),
        .in_valid        (s_tvalid),
        .in_ready        (s_tready),
        .cmd             (s_tdata[3:0]),
        .qubit_a         (s_tdata[7:4]),
        .qubit_b         (s_tdata[11:8]),
        .random_fraction (s_tdata[28:12]),
        .amp_index       (s_tdata[44:29]),
        .num_qubits      (num_qubits_reg),
        .out_free        (out_free),
        .res_valid       (res_valid),
        .res_status      (res_status),
        .res_index       (res_index),
        .res_re          (res_re),
        .res_im          (res_im)
    );

    // Qubit count register
    assign cfg_ready = 1'b1;
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            num_qubits_reg <= qsv_pkg::NQ_W'(1);
        end else if (cfg_valid) begin
            num_qubits_reg <= cfg_data;
        end
    end

    // Output register: free when empty or being taken
    assign out_free = !m_valid_reg || m_tready;
    always_comb begin
        m_valid_next = m_valid_reg;
        if (res_valid) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (res_valid) begin
            m_data_reg <= M_DATA_W'({res_im, res_re, res_index, res_status});
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = m_data_reg;

endmodule

[src/qsv_amp_mem.sv]
module qsv_amp_mem #(
    parameter int ADDR_W = 16,
    parameter int DATA_W = 36
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [DATA_W-1:0] wdata,
    input  logic [ADDR_W-1:0] raddr,
    output logic [DATA_W-1:0] rdata
);

    logic [DATA_W-1:0] mem [2**ADDR_W];

    // Write port
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
    end

    // Registered read port
    always_ff @(posedge aclk) begin
        rdata <= mem[raddr];
    end

endmodule

[src/qsv_gate_alu.sv]
module qsv_gate_alu #(
    parameter int AMP_FRAC_BITS = qsv_pkg::AMP_FRAC_BITS_DEF
) (
    input  logic                         aclk,
    input  qsv_pkg::alu_ctl_t            ctl,
    input  logic signed [AMP_FRAC_BITS+1:0] x_re,
    input  logic signed [AMP_FRAC_BITS+1:0] x_im,
    input  logic signed [AMP_FRAC_BITS+1:0] y_re,
    input  logic signed [AMP_FRAC_BITS+1:0] y_im,
    output logic signed [AMP_FRAC_BITS+1:0] nx_re,
    output logic signed [AMP_FRAC_BITS+1:0] nx_im,
    output logic signed [AMP_FRAC_BITS+1:0] ny_re,
    output logic signed [AMP_FRAC_BITS+1:0] ny_im
);

    localparam int F     = AMP_FRAC_BITS;
    localparam int AMP_W = F + 2;
    localparam int SUM_W = F + 3;
    localparam int PRD_W = 2 * F + 5;
    localparam longint unsigned S_VAL = qsv_pkg::root_half(F);
    localparam logic signed [F+1:0] S_COEF = (F + 2)'(S_VAL);
    localparam logic signed [AMP_W-1:0] AMP_MAX = {1'b0, {(AMP_W - 1){1'b1}}};
    localparam logic signed [AMP_W-1:0] AMP_MIN = {1'b1, {(AMP_W - 1){1'b0}}};
    localparam logic signed [PRD_W:0] HALF = (PRD_W + 1)'(1) <<< (F - 1);

    logic signed [SUM_W-1:0] a0, a1, a2, a3;
    logic signed [PRD_W-1:0] p0_reg, p1_reg, p2_reg, p3_reg;
    logic signed [AMP_W-1:0] xr_reg, xi_reg, yr_reg, yi_reg;
    qsv_pkg::gate_kind_t     kind_reg;

    // Round to nearest, ties up, then clamp
    function automatic logic signed [AMP_W-1:0] rnd(input logic signed [PRD_W-1:0] p);
        logic signed [PRD_W:0] v;
        logic signed [PRD_W:0] q;
        v = (PRD_W + 1)'(p) + HALF;
        q = v >>> F;
        if (q > (PRD_W + 1)'(AMP_MAX)) begin
            return AMP_MAX;
        end else if (q < (PRD_W + 1)'(AMP_MIN)) begin
            return AMP_MIN;
        end else begin
            return q[AMP_W-1:0];
        end
    endfunction

    // Negate with clamp of the most negative value
    function automatic logic signed [AMP_W-1:0] neg(input logic signed [AMP_W-1:0] v);
        if (v == AMP_MIN) begin
            return AMP_MAX;
        end else begin
            return -v;
        end
    endfunction

    // Pick multiplier operands
    always_comb begin
        a0 = SUM_W'(x_re) + SUM_W'(y_re);
        a1 = SUM_W'(x_im) + SUM_W'(y_im);
        a2 = SUM_W'(x_re) - SUM_W'(y_re);
        a3 = SUM_W'(x_im) - SUM_W'(y_im);
        if (ctl.kind == qsv_pkg::K_T) begin
            a2 = SUM_W'(y_re) - SUM_W'(y_im);
            a3 = SUM_W'(y_re) + SUM_W'(y_im);
        end
    end

    // Multiply stage
    always_ff @(posedge aclk) begin
        if (ctl.en) begin
            p0_reg   <= a0 * S_COEF;
            p1_reg   <= a1 * S_COEF;
            p2_reg   <= a2 * S_COEF;
            p3_reg   <= a3 * S_COEF;
            xr_reg   <= x_re;
            xi_reg   <= x_im;
            yr_reg   <= y_re;
            yi_reg   <= y_im;
            kind_reg <= ctl.kind;
        end
    end

    // Round and select the new pair
    always_comb begin
        nx_re = xr_reg;
        nx_im = xi_reg;
        ny_re = yr_reg;
        ny_im = yi_reg;
        case (kind_reg)
            qsv_pkg::K_H: begin
                nx_re = rnd(p0_reg);
                nx_im = rnd(p1_reg);
                ny_re = rnd(p2_reg);
                ny_im = rnd(p3_reg);
            end
            qsv_pkg::K_X: begin
                nx_re = yr_reg;
                nx_im = yi_reg;
                ny_re = xr_reg;
                ny_im = xi_reg;
            end
            qsv_pkg::K_Y: begin
                nx_re = yi_reg;
                nx_im = neg(yr_reg);
                ny_re = neg(xi_reg);
                ny_im = xr_reg;
            end
            qsv_pkg::K_Z: begin
                ny_re = neg(yr_reg);
                ny_im = neg(yi_reg);
            end
            qsv_pkg::K_S: begin
                ny_re = neg(yi_reg);
                ny_im = yr_reg;
            end
            qsv_pkg::K_T: begin
                ny_re = rnd(p2_reg);
                ny_im = rnd(p3_reg);
            end
            default: begin
                nx_re = xr_reg;
            end
        endcase
    end

endmodule

[src/qsv_ctrl.sv]
module qsv_ctrl #(
    parameter int MAX_QUBIT_COUNT = qsv_pkg::MAX_QUBIT_COUNT_DEF,
    parameter int AMP_FRAC_BITS   = qsv_pkg::AMP_FRAC_BITS_DEF
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic [qsv_pkg::CMD_W-1:0]             cmd,
    input  logic [qsv_pkg::QUBIT_W-1:0]           qubit_a,
    input  logic [qsv_pkg::QUBIT_W-1:0]           qubit_b,
    input  logic [qsv_pkg::RAND_W-1:0]            random_fraction,
    input  logic [qsv_pkg::INDEX_W-1:0]           amp_index,
    input  logic [qsv_pkg::NQ_W-1:0]              num_qubits,
    input  logic                                  out_free,
    output logic                                  res_valid,
    output logic [qsv_pkg::STATUS_W-1:0]          res_status,
    output logic [qsv_pkg::INDEX_W-1:0]           res_index,
    output logic signed [AMP_FRAC_BITS+1:0]       res_re,
    output logic signed [AMP_FRAC_BITS+1:0]       res_im
);

    localparam int AW     = MAX_QUBIT_COUNT;
    localparam int F      = AMP_FRAC_BITS;
    localparam int AMP_W  = F + 2;
    localparam int DW     = 2 * AMP_W;
    localparam int SQ_W   = 2 * AMP_W;
    localparam int ACC_W  = 2 * F + 4 + MAX_QUBIT_COUNT;
    localparam int THR_SH = 2 * F - 16;
    localparam logic [DW-1:0] AMP_ONE = DW'(1) << F;
    localparam logic [qsv_pkg::NQ_W-1:0] NQ_MAX = qsv_pkg::NQ_W'(MAX_QUBIT_COUNT);

    qsv_pkg::ctrl_state_t state_reg, state_next;

    logic [AW-1:0]                 i_reg, i_next;
    logic [AW-1:0]                 j_reg, j_next;
    logic [AW-1:0]                 pm_reg, pm_next;
    logic [AW-1:0]                 lb_reg, lb_next;
    logic [qsv_pkg::CMD_W-1:0]     cmd_reg, cmd_next;
    logic [DW-1:0]                 x_reg, x_next;
    logic [SQ_W-1:0]               sqr_reg, sqr_next;
    logic [SQ_W-1:0]               sqi_reg, sqi_next;
    logic [ACC_W-1:0]              acc_reg, acc_next;
    logic [ACC_W:0]                thr_reg, thr_next;
    logic [qsv_pkg::STATUS_W-1:0]  status_reg, status_next;
    logic [qsv_pkg::INDEX_W-1:0]   mi_reg, mi_next;
    logic signed [AMP_W-1:0]       re_reg, re_next;
    logic signed [AMP_W-1:0]       im_reg, im_next;

    logic [qsv_pkg::NQ_W-1:0] n_eff;
    logic [qsv_pkg::NQ_W-1:0] qa5, qb5;
    logic                     qa_bad, qb_bad;
    logic [AW-1:0]            span_mask, mask_a, mask_b;
    logic                     i_last, i_full;
    logic                     pair_hit;
    logic [AW-1:0]            j_calc;
    logic [ACC_W:0]           tot;
    logic [SQ_W:0]            prob;
    logic [AMP_W-1:0]         mag_re, mag_im;

    logic                     mem_we;
    logic [AW-1:0]            mem_waddr, mem_raddr;
    logic [DW-1:0]            mem_wdata, mem_rdata;
    qsv_pkg::alu_ctl_t        alu_ctl;
    logic signed [AMP_W-1:0]  nx_re, nx_im, ny_re, ny_im;

    qsv_amp_mem #(
        .ADDR_W (AW),
        .DATA_W (DW)
    ) u_mem (
        .aclk  (aclk),
        .we    (mem_we),
        .waddr (mem_waddr),
        .wdata (mem_wdata),
        .raddr (mem_raddr),
        .rdata (mem_rdata)
    );

    qsv_gate_alu #(
        .AMP_FRAC_BITS (AMP_FRAC_BITS)
    ) u_alu (
        .aclk  (aclk),
        .ctl   (alu_ctl),
        .x_re  (x_reg[AMP_W-1:0]),
        .x_im  (x_reg[DW-1:AMP_W]),
        .y_re  (mem_rdata[AMP_W-1:0]),
        .y_im  (mem_rdata[DW-1:AMP_W]),
        .nx_re (nx_re),
        .nx_im (nx_im),
        .ny_re (ny_re),
        .ny_im (ny_im)
    );

    // Qubit count, masks and operand checks
    always_comb begin
        if (num_qubits == '0) begin
            n_eff = qsv_pkg::NQ_W'(1);
        end else if (num_qubits > NQ_MAX) begin
            n_eff = NQ_MAX;
        end else begin
            n_eff = num_qubits;
        end
        qa5       = qsv_pkg::NQ_W'(qubit_a);
        qb5       = qsv_pkg::NQ_W'(qubit_b);
        qa_bad    = qa5 >= n_eff;
        qb_bad    = qb5 >= n_eff;
        span_mask = ~({AW{1'b1}} << n_eff);
        mask_a    = AW'(1) << (n_eff - qsv_pkg::NQ_W'(1) - qa5);
        mask_b    = AW'(1) << (n_eff - qsv_pkg::NQ_W'(1) - qb5);
        i_last    = i_reg == span_mask;
        i_full    = i_reg == {AW{1'b1}};
    end

    // Pair test for the current index
    always_comb begin
        if (cmd_reg == qsv_pkg::CMD_CX) begin
            pair_hit = ((i_reg & pm_reg) != '0) && ((i_reg & lb_reg) == '0);
            j_calc   = i_reg | lb_reg;
        end else if (cmd_reg == qsv_pkg::CMD_SWAP) begin
            pair_hit = ((i_reg & pm_reg) != '0) && ((i_reg & lb_reg) == '0);
            j_calc   = (i_reg & ~pm_reg) | lb_reg;
        end else begin
            pair_hit = (i_reg & pm_reg) == '0;
            j_calc   = i_reg | pm_reg;
        end
    end

    // Probability and running sum
    always_comb begin
        mag_re = mem_rdata[AMP_W-1] ? AMP_W'(-mem_rdata[AMP_W-1:0])
                                    : mem_rdata[AMP_W-1:0];
        mag_im = mem_rdata[DW-1] ? AMP_W'(-mem_rdata[DW-1:AMP_W])
                                 : mem_rdata[DW-1:AMP_W];
        prob   = (SQ_W + 1)'(sqr_reg) + (SQ_W + 1)'(sqi_reg);
        tot    = (ACC_W + 1)'(acc_reg) + (ACC_W + 1)'(prob);
    end

    // Next state
    always_comb begin
        state_next = state_reg;
        case (state_reg)
            qsv_pkg::ST_CLR_RST: begin
                if (i_full) state_next = qsv_pkg::ST_IDLE;
            end
            qsv_pkg::ST_IDLE: begin
                if (in_valid) begin
                    if (cmd inside {[qsv_pkg::CMD_H:qsv_pkg::CMD_T]}) begin
                        state_next = qa_bad ? qsv_pkg::ST_DONE : qsv_pkg::ST_SCAN;
                    end else if (cmd inside {qsv_pkg::CMD_CX, qsv_pkg::CMD_SWAP}) begin
                        state_next = (qa_bad || qb_bad || qubit_a == qubit_b)
                                   ? qsv_pkg::ST_DONE : qsv_pkg::ST_SCAN;
                    end else if (cmd == qsv_pkg::CMD_MEAS) begin
                        state_next = qsv_pkg::ST_MS_RD;
                    end else if (cmd == qsv_pkg::CMD_READ) begin
                        state_next = qsv_pkg::ST_RD_ISSUE;
                    end else if (cmd == qsv_pkg::CMD_INIT) begin
                        state_next = qsv_pkg::ST_CLR_CMD;
                    end else begin
                        state_next = qsv_pkg::ST_DONE;
                    end
                end
            end
            qsv_pkg::ST_SCAN: begin
                if (pair_hit) begin
                    state_next = qsv_pkg::ST_PAIR_RX;
                end else if (i_last) begin
                    state_next = qsv_pkg::ST_DONE;
                end
            end
            qsv_pkg::ST_PAIR_RX:  state_next = qsv_pkg::ST_PAIR_RY;
            qsv_pkg::ST_PAIR_RY:  state_next = qsv_pkg::ST_PAIR_MUL;
            qsv_pkg::ST_PAIR_MUL: state_next = qsv_pkg::ST_PAIR_WX;
            qsv_pkg::ST_PAIR_WX:  state_next = qsv_pkg::ST_PAIR_WY;
            qsv_pkg::ST_PAIR_WY: begin
                state_next = i_last ? qsv_pkg::ST_DONE : qsv_pkg::ST_SCAN;
            end
            qsv_pkg::ST_MS_RD: state_next = qsv_pkg::ST_MS_SQ;
            qsv_pkg::ST_MS_SQ: state_next = qsv_pkg::ST_MS_ACC;
            qsv_pkg::ST_MS_ACC: begin
                state_next = (tot >= thr_reg || i_last) ? qsv_pkg::ST_DONE
                                                        : qsv_pkg::ST_MS_RD;
            end
            qsv_pkg::ST_RD_ISSUE: state_next = qsv_pkg::ST_RD_DATA;
            qsv_pkg::ST_RD_DATA:  state_next = qsv_pkg::ST_DONE;
            qsv_pkg::ST_CLR_CMD: begin
                if (i_full) state_next = qsv_pkg::ST_DONE;
            end
            qsv_pkg::ST_DONE: begin
                if (out_free) state_next = qsv_pkg::ST_IDLE;
            end
            default: state_next = qsv_pkg::ST_IDLE;
        endcase
    end

    // Datapath, memory port and handshake outputs
    always_comb begin
        i_next      = i_reg;
        j_next      = j_reg;
        pm_next     = pm_reg;
        lb_next     = lb_reg;
        cmd_next    = cmd_reg;
        x_next      = x_reg;
        sqr_next    = sqr_reg;
        sqi_next    = sqi_reg;
        acc_next    = acc_reg;
        thr_next    = thr_reg;
        status_next = status_reg;
        mi_next     = mi_reg;
        re_next     = re_reg;
        im_next     = im_reg;
        mem_we      = 1'b0;
        mem_waddr   = i_reg;
        mem_wdata   = '0;
        mem_raddr   = i_reg;
        alu_ctl.en   = 1'b0;
        alu_ctl.kind = (cmd_reg inside {[qsv_pkg::CMD_H:qsv_pkg::CMD_T]})
                     ? qsv_pkg::gate_kind_t'(cmd_reg[2:0]) : qsv_pkg::K_X;
        in_ready    = state_reg == qsv_pkg::ST_IDLE;
        res_valid   = (state_reg == qsv_pkg::ST_DONE) && out_free;
        case (state_reg)
            qsv_pkg::ST_IDLE: begin
                if (in_valid) begin
                    cmd_next    = cmd;
                    status_next = qsv_pkg::STAT_OK;
                    mi_next     = '0;
                    re_next     = '0;
                    im_next     = '0;
                    pm_next     = mask_a;
                    lb_next     = mask_b;
                    acc_next    = '0;
                    thr_next    = (ACC_W + 1)'(random_fraction) << THR_SH;
                    i_next      = '0;
                    if (cmd inside {[qsv_pkg::CMD_H:qsv_pkg::CMD_T]}) begin
                        if (qa_bad) status_next = qsv_pkg::STAT_RANGE;
                    end else if (cmd inside {qsv_pkg::CMD_CX, qsv_pkg::CMD_SWAP}) begin
                        if (qa_bad || qb_bad) begin
                            status_next = qsv_pkg::STAT_RANGE;
                        end else if (qubit_a == qubit_b && cmd == qsv_pkg::CMD_CX) begin
                            status_next = qsv_pkg::STAT_SAME;
                        end
                    end else if (cmd == qsv_pkg::CMD_READ) begin
                        i_next = AW'(amp_index) & span_mask;
                    end
                end
            end
            qsv_pkg::ST_SCAN: begin
                j_next = j_calc;
                if (!pair_hit && !i_last) i_next = i_reg + AW'(1);
            end
            qsv_pkg::ST_PAIR_RY: begin
                x_next    = mem_rdata;
                mem_raddr = j_reg;
            end
            qsv_pkg::ST_PAIR_MUL: begin
                alu_ctl.en = 1'b1;
            end
            qsv_pkg::ST_PAIR_WX: begin
                mem_we    = 1'b1;
                mem_wdata = {nx_im, nx_re};
            end
            qsv_pkg::ST_PAIR_WY: begin
                mem_we    = 1'b1;
                mem_waddr = j_reg;
                mem_wdata = {ny_im, ny_re};
                if (!i_last) i_next = i_reg + AW'(1);
            end
            qsv_pkg::ST_MS_SQ: begin
                sqr_next = SQ_W'(mag_re) * SQ_W'(mag_re);
                sqi_next = SQ_W'(mag_im) * SQ_W'(mag_im);
            end
            qsv_pkg::ST_MS_ACC: begin
                if (tot >= thr_reg || i_last) begin
                    mi_next = qsv_pkg::INDEX_W'(i_reg);
                end else begin
                    acc_next = tot[ACC_W-1:0];
                    i_next   = i_reg + AW'(1);
                end
            end
            qsv_pkg::ST_RD_DATA: begin
                re_next = mem_rdata[AMP_W-1:0];
                im_next = mem_rdata[DW-1:AMP_W];
            end
            qsv_pkg::ST_CLR_RST, qsv_pkg::ST_CLR_CMD: begin
                mem_we    = 1'b1;
                mem_wdata = (i_reg == '0) ? AMP_ONE : '0;
                i_next    = i_reg + AW'(1);
            end
            default: begin
                mem_we = 1'b0;
            end
        endcase
    end

    assign res_status = status_reg;
    assign res_index  = mi_reg;
    assign res_re     = re_reg;
    assign res_im     = im_reg;

    // Control registers
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= qsv_pkg::ST_CLR_RST;
            i_reg     <= '0;
        end else begin
            state_reg <= state_next;
            i_reg     <= i_next;
        end
    end

    // Payload registers
    always_ff @(posedge aclk) begin
        j_reg      <= j_next;
        pm_reg     <= pm_next;
        lb_reg     <= lb_next;
        cmd_reg    <= cmd_next;
        x_reg      <= x_next;
        sqr_reg    <= sqr_next;
        sqi_reg    <= sqi_next;
        acc_reg    <= acc_next;
        thr_reg    <= thr_next;
        status_reg <= status_next;
        mi_reg     <= mi_next;
        re_reg     <= re_next;
        im_reg     <= im_next;
    end

endmodule
